/* design/mbet_pkg.sv */
// Shared types and constants for the master board election table.
package mbet_pkg;

    localparam int GROUP_SIZE = 4;
    localparam int IDX_W      = 2;
    localparam int CNT_W      = $clog2(GROUP_SIZE + 1);

    localparam logic [15:0] MARGIN_RESET = 16'd10;

    localparam logic [2:0] ROLE_BACKUP  = 3'd0;
    localparam logic [2:0] ROLE_MASTER  = 3'd1;
    localparam logic [2:0] ROLE_TOBE    = 3'd2;
    localparam logic [2:0] ROLE_OFFLINE = 3'd3;

    localparam logic [2:0] ADDR_MARGIN = 3'd0;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_SELECT = 2'd1,
        REQ_PROBE  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_UPDATED    = 3'd0,
        ST_ADDED      = 3'd1,
        ST_FULL       = 3'd2,
        ST_CHIEF      = 3'd3,
        ST_EMPTY      = 3'd4,
        ST_FOUND      = 3'd5,
        ST_NO_TIMEOUT = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_NEXT,
        OP_UPDATE,
        OP_APPEND,
        OP_FULL,
        OP_EMPTY,
        OP_ELECT,
        OP_NEXT_PASS,
        OP_APPLY,
        OP_OFFLINE,
        OP_PASS_FLAG,
        OP_NO_TIMEOUT,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADD,
        S_SEL,
        S_PROBE,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  slot_id;
        logic [2:0]  slot_role;
        logic [31:0] uptime;
        logic        probe_flag;
        logic [1:0]  probe_start;
    } t_item;

    typedef struct packed {
        logic [2:0] status;
        logic [1:0] entry_index;
        logic [7:0] chief_slot;
        logic       election_pending;
    } t_result;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic empty;
        logic full;
        logic at_end;
        logic hit;
        logic flag_set;
        logic have;
        logic pass_last;
        logic out_free;
    } t_sts;

endpackage

/* design/mbet_in_if.sv */
// Request channel: one beat carries one request item.
interface mbet_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  slot_id;
    logic [2:0]  slot_role;
    logic [31:0] uptime;
    logic        probe_flag;
    logic [1:0]  probe_start;

    modport source (
        output valid, req_type, slot_id, slot_role, uptime, probe_flag, probe_start,
        input  ready
    );
    modport sink (
        input  valid, req_type, slot_id, slot_role, uptime, probe_flag, probe_start,
        output ready
    );
endinterface

/* design/mbet_out_if.sv */
// Result channel: one beat carries one result item.
interface mbet_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [1:0] entry_index;
    logic [7:0] chief_slot;
    logic       election_pending;

    modport source (
        output valid, status, entry_index, chief_slot, election_pending,
        input  ready
    );
    modport sink (
        input  valid, status, entry_index, chief_slot, election_pending,
        output ready
    );
endinterface

/* design/mbet_ctrl.sv */
// Sequencer for add, select and probe walks over the member table.
module mbet_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  mbet_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output mbet_pkg::t_cmd o_cmd
);
    import mbet_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_sts.req)
                    REQ_ADD:    n_state = S_ADD;
                    REQ_SELECT: n_state = i_sts.empty ? S_RESULT : S_SEL;
                    REQ_PROBE:  n_state = S_PROBE;
                    REQ_NONE:   n_state = S_IDLE;
                endcase
            end
            S_ADD: begin
                if (i_sts.at_end || i_sts.hit) begin
                    n_state = S_RESULT;
                end
            end
            S_SEL: begin
                if (i_sts.at_end && (i_sts.have || i_sts.pass_last)) begin
                    n_state = S_RESULT;
                end
            end
            S_PROBE: begin
                if (i_sts.at_end || i_sts.flag_set) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op   = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_CAPTURE;
                end
            end
            S_DISPATCH: begin
                if (i_sts.req == REQ_SELECT && i_sts.empty) begin
                    o_cmd.op = OP_EMPTY;
                end
            end
            S_ADD: begin
                priority if (i_sts.at_end) begin
                    o_cmd.op = i_sts.full ? OP_FULL : OP_APPEND;
                end else if (i_sts.hit) begin
                    o_cmd.op = OP_UPDATE;
                end else begin
                    o_cmd.op = OP_NEXT;
                end
            end
            S_SEL: begin
                priority if (i_sts.at_end && (i_sts.have || i_sts.pass_last)) begin
                    o_cmd.op = OP_APPLY;
                end else if (i_sts.at_end) begin
                    o_cmd.op = OP_NEXT_PASS;
                end else begin
                    o_cmd.op = OP_ELECT;
                end
            end
            S_PROBE: begin
                priority if (i_sts.at_end) begin
                    o_cmd.op = OP_NO_TIMEOUT;
                end else if (i_sts.flag_set) begin
                    o_cmd.op = OP_OFFLINE;
                end else begin
                    o_cmd.op = OP_PASS_FLAG;
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_EMIT;
                end
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

/* design/mbet_dp.sv */
// Member table, walk counters, election compare and result register.
module mbet_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mbet_pkg::t_cmd    i_cmd,
    input  mbet_pkg::t_item   i_item,
    input  logic [15:0]      i_margin,
    input  logic             i_out_ready,
    output mbet_pkg::t_sts    o_sts,
    output logic             o_out_valid,
    output mbet_pkg::t_result o_out
);
    import mbet_pkg::*;

    function automatic logic [2:0] pass_role(input logic [1:0] pass);
        logic [2:0] role;
        unique case (pass)
            2'd0:    role = ROLE_TOBE;
            2'd1:    role = ROLE_MASTER;
            default: role = ROLE_BACKUP;
        endcase
        return role;
    endfunction

    logic [7:0]  r_slot [GROUP_SIZE];
    logic [2:0]  r_role [GROUP_SIZE];
    logic [31:0] r_up   [GROUP_SIZE];
    logic        r_flag [GROUP_SIZE];

    t_item       r_item;
    logic [CNT_W-1:0] r_idx;
    logic [1:0]  r_pass;
    logic        r_have;
    logic [IDX_W-1:0] r_best;
    logic [31:0] r_best_up;
    logic [7:0]  r_best_slot;

    logic [CNT_W-1:0] r_count;
    logic        r_pending;
    logic [7:0]  r_chief_slot;
    t_status     r_res_status;
    logic [IDX_W-1:0] r_res_idx;
    logic        r_out_valid;
    t_result     r_out;

    logic [IDX_W-1:0] ix;
    logic [7:0]  cur_slot;
    logic [2:0]  cur_role;
    logic [31:0] cur_up;
    logic [32:0] best_limit;
    logic        role_match;
    logic        beats;
    logic [IDX_W-1:0] win_idx;
    logic [7:0]  win_slot;

    assign ix         = r_idx[IDX_W-1:0];
    assign cur_slot   = r_slot[ix];
    assign cur_role   = r_role[ix];
    assign cur_up     = r_up[ix];
    assign best_limit = {1'b0, r_best_up} + {17'b0, i_margin};
    assign role_match = (cur_role == pass_role(r_pass));
    assign beats      = ({1'b0, cur_up} > best_limit)
                     || (cur_up == r_best_up && cur_slot < r_best_slot);
    assign win_idx    = r_have ? r_best : '0;
    assign win_slot   = r_have ? r_best_slot : r_slot[0];

    always_comb begin
        o_sts.req       = t_req'(r_item.req_type);
        o_sts.empty     = (r_count == '0);
        o_sts.full      = (r_count == CNT_W'(GROUP_SIZE));
        o_sts.at_end    = (r_idx >= r_count);
        o_sts.hit       = (cur_slot == r_item.slot_id);
        o_sts.flag_set  = r_flag[ix];
        o_sts.have      = r_have;
        o_sts.pass_last = (r_pass == 2'd2);
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    // table entries and walk registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_CAPTURE: begin
                r_item <= i_item;
                r_idx  <= (t_req'(i_item.req_type) == REQ_PROBE)
                        ? CNT_W'(i_item.probe_start) : '0;
                r_pass <= '0;
                r_have <= 1'b0;
            end
            OP_NEXT: r_idx <= r_idx + 1'b1;
            OP_UPDATE, OP_APPEND: begin
                if (i_cmd.op == OP_APPEND) begin
                    r_slot[ix] <= r_item.slot_id;
                end
                r_role[ix]   <= r_item.slot_role;
                r_up[ix]     <= r_item.uptime;
                r_flag[ix]   <= r_item.probe_flag;
                r_res_status <= (i_cmd.op == OP_APPEND) ? ST_ADDED : ST_UPDATED;
                r_res_idx    <= ix;
            end
            OP_FULL: begin
                r_res_status <= ST_FULL;
                r_res_idx    <= '0;
            end
            OP_EMPTY: begin
                r_res_status <= ST_EMPTY;
                r_res_idx    <= '0;
            end
            OP_ELECT: begin
                if (role_match && (!r_have || beats)) begin
                    r_best      <= ix;
                    r_best_up   <= cur_up;
                    r_best_slot <= cur_slot;
                    r_have      <= 1'b1;
                end
                r_idx <= r_idx + 1'b1;
            end
            OP_NEXT_PASS: begin
                r_pass <= r_pass + 1'b1;
                r_idx  <= '0;
            end
            OP_APPLY: begin
                for (int i = 0; i < GROUP_SIZE; i++) begin
                    if (CNT_W'(i) < r_count) begin
                        r_role[i] <= (IDX_W'(i) == win_idx) ? ROLE_MASTER : ROLE_BACKUP;
                    end
                end
                r_res_status <= ST_CHIEF;
                r_res_idx    <= win_idx;
            end
            OP_OFFLINE: begin
                r_role[ix]   <= ROLE_OFFLINE;
                r_res_status <= ST_FOUND;
                r_res_idx    <= ix;
            end
            OP_PASS_FLAG: begin
                r_flag[ix] <= 1'b1;
                r_idx      <= r_idx + 1'b1;
            end
            OP_NO_TIMEOUT: begin
                r_res_status <= ST_NO_TIMEOUT;
                r_res_idx    <= '0;
            end
            OP_EMIT: begin
                r_out.status           <= r_res_status;
                r_out.entry_index      <= r_res_idx;
                r_out.chief_slot       <= r_chief_slot;
                r_out.election_pending <= r_pending;
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_pending    <= 1'b0;
            r_chief_slot <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.op == OP_APPEND) begin
                r_count   <= r_count + 1'b1;
                r_pending <= 1'b1;
            end
            if (i_cmd.op == OP_APPLY) begin
                r_chief_slot <= win_slot;
                r_pending    <= 1'b0;
            end
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(GROUP_SIZE))
        else $error("member count above group size");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_APPEND |=> r_count == $past(r_count) + 1'b1 && r_pending)
        else $error("append did not grow the table");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_EMIT |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten while stalled");

    a_apply_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_APPLY |=> !r_pending)
        else $error("pending mark left set after election");
`endif

endmodule

/* design/master_board_election_table.sv */
// Top level of the master board election table.
//
// Requests enter on i_in (valid/ready); each beat is add/update, select chief
// or timeout probe. Every request except the unused type gives one result
// beat on o_out with status, entry index, current chief slot and the
// election pending mark. The unused type is dropped without a result.
// uptime_margin sits at APB address 0 (reset 10); write it while idle.
// The block works on one request at a time, walking the four-entry table
// one entry per cycle in the sequencer:
//   add/update  dispatch, walk to the matching slot or the table end, emit
//   select      dispatch, up to three role passes of up to five steps (the
//               last step of a pass applying the winner once found), emit;
//               only dispatch and emit on an empty table
//   probe       dispatch, walk to a flagged entry or the table end, emit
// and the sequencer returns to idle before the next request is taken.
// Reset empties the table, clears the chief and pending mark; entry
// contents are not cleared. A stalled result is held in the output
// register; the next request is accepted and worked on meanwhile, and its
// result waits until the held beat is taken.
module master_board_election_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbet_in_if.sink     i_in,
    mbet_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mbet_pkg::*;

    logic [15:0] r_margin;
    t_cmd        cmd;
    t_sts        sts;
    t_item       item;
    t_result     res;
    logic        in_ready;
    logic        out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= MARGIN_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_MARGIN) begin
            r_margin <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MARGIN) ? {16'b0, r_margin} : 32'b0;

    assign item.req_type    = i_in.req_type;
    assign item.slot_id     = i_in.slot_id;
    assign item.slot_role   = i_in.slot_role;
    assign item.uptime      = i_in.uptime;
    assign item.probe_flag  = i_in.probe_flag;
    assign item.probe_start = i_in.probe_start;
    assign i_in.ready       = in_ready;

    mbet_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    mbet_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (item),
        .i_margin    (r_margin),
        .i_out_ready (o_out.ready),
        .o_sts       (sts),
        .o_out_valid (out_valid),
        .o_out       (res)
    );

    assign o_out.valid            = out_valid;
    assign o_out.status           = res.status;
    assign o_out.entry_index      = res.entry_index;
    assign o_out.chief_slot       = res.chief_slot;
    assign o_out.election_pending = res.election_pending;

endmodule
